// ===== src/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// shared types, codes and the fixed step tables of the command sequencer
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_PROCESSING = 3'd1;
  localparam logic [2:0] ST_WAKE_OK    = 3'd2;
  localparam logic [2:0] ST_WAKE_TMO   = 3'd3;
  localparam logic [2:0] ST_FINISHED   = 3'd4;

  localparam logic [3:0] FR_WAKEUP       = 4'd0;
  localparam logic [3:0] FR_HVAC_INIT    = 4'd1;
  localparam logic [3:0] FR_IDLE         = 4'd2;
  localparam logic [3:0] FR_HVAC_ON      = 4'd3;
  localparam logic [3:0] FR_HVAC_ON_IDLE = 4'd4;
  localparam logic [3:0] FR_INTERRUPT    = 4'd5;
  localparam logic [3:0] FR_HVAC_OFF     = 4'd6;
  localparam logic [3:0] FR_CHARGE      = 4'd7;
  localparam logic [3:0] FR_UNLOCK       = 4'd8;
  localparam logic [3:0] FR_LOCK         = 4'd9;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_REFRESH  = 3'd1;
  localparam logic [2:0] CMD_CLIM_ON  = 3'd2;
  localparam logic [2:0] CMD_CLIM_OFF = 3'd3;
  localparam logic [2:0] CMD_CHARGE   = 3'd4;
  localparam logic [2:0] CMD_UNLOCK   = 3'd5;
  localparam logic [2:0] CMD_LOCK     = 3'd6;
  localparam logic [2:0] CMD_RESERVED = 3'd7;

  localparam logic [10:0] WAKE_PERIOD_MS = 11'd15;
  localparam logic [10:0] WAKE_SETTLE_MS = 11'd50;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic [2:0]  sequence_select;
    logic        awake_event;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       start_accepted;
    logic       send_valid;
    logic [3:0] frame_index;
    logic       patch_setpoint;
    logic [7:0] setpoint_byte;
  } result_t;

  // wait is the larger of the step delay and its interval
  typedef struct packed {
    logic [3:0]  frame;
    logic [5:0]  repeats;
    logic [10:0] interval;
    logic [10:0] wait_ms;
    logic        patch;
  } step_t;

  function automatic step_t mk_step(logic [3:0] frame, logic [5:0] repeats,
                                    logic [10:0] interval, logic [10:0] wait_ms,
                                    logic patch);
    step_t s;
    s.frame    = frame;
    s.repeats  = repeats;
    s.interval = interval;
    s.wait_ms  = wait_ms;
    s.patch    = patch;
    return s;
  endfunction

  function automatic logic [2:0] seq_len(logic [2:0] seq);
    logic [2:0] len;
    case (seq)
      CMD_REFRESH:  len = 3'd2;
      CMD_CLIM_ON:  len = 3'd4;
      CMD_CLIM_OFF: len = 3'd5;
      CMD_CHARGE:   len = 3'd2;
      CMD_UNLOCK:   len = 3'd2;
      CMD_LOCK:     len = 3'd2;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic step_t step_lookup(logic [2:0] seq, logic [2:0] pos);
    step_t s;
    s = mk_step(FR_WAKEUP, 6'd0, 11'd0, 11'd0, 1'b0);
    case ({seq, pos})
      {CMD_REFRESH, 3'd0}:  s = mk_step(FR_HVAC_INIT, 6'd20, 11'd100, 11'd1000, 1'b0);
      {CMD_REFRESH, 3'd1}:  s = mk_step(FR_IDLE, 6'd20, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_ON, 3'd0}:  s = mk_step(FR_HVAC_INIT, 6'd20, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_ON, 3'd1}:  s = mk_step(FR_HVAC_ON, 6'd25, 11'd100, 11'd100, 1'b1);
      {CMD_CLIM_ON, 3'd2}:  s = mk_step(FR_HVAC_ON_IDLE, 6'd40, 11'd100, 11'd100, 1'b1);
      {CMD_CLIM_ON, 3'd3}:  s = mk_step(FR_IDLE, 6'd50, 11'd100, 11'd100, 1'b1);
      {CMD_CLIM_OFF, 3'd0}: s = mk_step(FR_HVAC_INIT, 6'd10, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_OFF, 3'd1}: s = mk_step(FR_INTERRUPT, 6'd9, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_OFF, 3'd2}: s = mk_step(FR_HVAC_OFF, 6'd8, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_OFF, 3'd3}: s = mk_step(FR_HVAC_INIT, 6'd4, 11'd100, 11'd100, 1'b0);
      {CMD_CLIM_OFF, 3'd4}: s = mk_step(FR_IDLE, 6'd8, 11'd100, 11'd100, 1'b0);
      {CMD_CHARGE, 3'd0}:   s = mk_step(FR_CHARGE, 6'd20, 11'd100, 11'd100, 1'b0);
      {CMD_CHARGE, 3'd1}:   s = mk_step(FR_IDLE, 6'd8, 11'd100, 11'd100, 1'b0);
      {CMD_UNLOCK, 3'd0}:   s = mk_step(FR_UNLOCK, 6'd1, 11'd100, 11'd100, 1'b0);
      {CMD_UNLOCK, 3'd1}:   s = mk_step(FR_IDLE, 6'd8, 11'd100, 11'd100, 1'b0);
      {CMD_LOCK, 3'd0}:     s = mk_step(FR_LOCK, 6'd1, 11'd100, 11'd100, 1'b0);
      {CMD_LOCK, 3'd1}:     s = mk_step(FR_IDLE, 6'd8, 11'd100, 11'd100, 1'b0);
      default:              s = mk_step(FR_WAKEUP, 6'd0, 11'd0, 11'd0, 1'b0);
    endcase
    return s;
  endfunction

endpackage

// ===== src/timed_can_command_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// timed_can_command_sequencer_unit
// timed CAN command sequencer: wake phase, settle wait and step table playback
// ----------------------------------------------------------------------------
// Each input transaction (a tick or a start request) gives exactly one result
// transaction. An accepted item lands in an input register, is decided by one
// pass of compare, step table lookup and a single due-time adder, and the
// result is captured in an output register as the item leaves the input
// register; out_valid comes from that output register. One item is taken
// every cycle; back-pressure from out_ready stalls both registers, and the
// input register still refills while it is empty. Write the setpoint
// register through the cfg channel only while no transaction is in flight,
// since a buffered item picks up the new value.
module timed_can_command_sequencer_unit #(
  parameter int WAKE_ATTEMPT_LIMIT = 130,
  parameter int TIME_BITS          = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] now_ms,
  input  logic [2:0]  sequence_select,
  input  logic        awake_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        start_accepted,
  output logic        send_valid,
  output logic [3:0]  frame_index,
  output logic        patch_setpoint,
  output logic [7:0]  setpoint_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  setpoint_half_degrees
);

  logic              ireg_valid;
  tccs_pkg::item_t   ireg;
  logic              oreg_valid;
  tccs_pkg::result_t oreg;
  tccs_pkg::result_t core_result;
  logic [7:0]        setpoint;
  logic              adv;

  assign adv       = ireg_valid && (!oreg_valid || out_ready);
  assign in_ready  = !ireg_valid || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= 8'd0;
    end else if (cfg_valid) begin
      setpoint <= setpoint_half_degrees;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg.opcode          <= opcode;
      ireg.now_ms          <= now_ms;
      ireg.sequence_select <= sequence_select;
      ireg.awake_event     <= awake_event;
    end
  end

  tccs_core #(
    .WAKE_ATTEMPT_LIMIT(WAKE_ATTEMPT_LIMIT),
    .TIME_BITS         (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (adv),
    .item    (ireg),
    .setpoint(setpoint),
    .result  (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      oreg_valid <= 1'b0;
    end else if (adv) begin
      oreg_valid <= 1'b1;
    end else if (out_ready) begin
      oreg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oreg <= core_result;
    end
  end

  assign out_valid      = oreg_valid;
  assign status         = oreg.status;
  assign start_accepted = oreg.start_accepted;
  assign send_valid     = oreg.send_valid;
  assign frame_index    = oreg.frame_index;
  assign patch_setpoint = oreg.patch_setpoint;
  assign setpoint_byte  = oreg.setpoint_byte;

endmodule

// ===== src/tccs_core.sv =====
// ----------------------------------------------------------------------------
// tccs_core
// sequencer state and the single pass decision for one transaction
// ----------------------------------------------------------------------------
module tccs_core #(
  parameter int WAKE_ATTEMPT_LIMIT = 130,
  parameter int TIME_BITS          = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tccs_pkg::item_t  item,
  input  logic [7:0]       setpoint,
  output tccs_pkg::result_t result
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAKING    = 2'd1;
  localparam logic [1:0] PH_WAKE_WAIT = 2'd2;
  localparam logic [1:0] PH_RUN       = 2'd3;

  logic [2:0]           active_sequence, active_sequence_next;
  logic [1:0]           phase, phase_next;
  logic [7:0]           wake_attempt_count, wake_attempt_count_next;
  logic [2:0]           step_position, step_position_next;
  logic [5:0]           repeat_counter, repeat_counter_next;
  logic [TIME_BITS-1:0] next_due_ms, next_due_ms_next;
  logic                 awake_latched, awake_latched_next;

  logic [TIME_BITS-1:0] now_ext;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] due_sum;
  logic [10:0]          addend;
  logic                 early;
  logic                 latched;
  logic [5:0]           repeat_inc;
  tccs_pkg::step_t      step;
  logic [2:0]           len;

  generate
    if (TIME_BITS <= 32) begin : g_narrow
      assign now_ext = item.now_ms[TIME_BITS-1:0];
    end else begin : g_wide
      assign now_ext = {{(TIME_BITS-32){1'b0}}, item.now_ms};
    end
  endgenerate

  assign diff       = now_ext - next_due_ms;
  assign early      = diff[TIME_BITS-1];
  assign latched    = awake_latched | item.awake_event;
  assign step       = tccs_pkg::step_lookup(active_sequence, step_position);
  assign len        = tccs_pkg::seq_len(active_sequence);
  assign repeat_inc = repeat_counter + 6'd1;
  assign due_sum    = now_ext + TIME_BITS'(addend);

  always_comb begin
    active_sequence_next    = active_sequence;
    phase_next              = phase;
    wake_attempt_count_next = wake_attempt_count;
    step_position_next      = step_position;
    repeat_counter_next     = repeat_counter;
    next_due_ms_next        = next_due_ms;
    awake_latched_next      = latched;
    addend                  = 11'd0;
    result                  = '0;
    result.status           = tccs_pkg::ST_IDLE;

    if (item.opcode == tccs_pkg::OP_START) begin
      if (item.sequence_select != tccs_pkg::CMD_NONE &&
          item.sequence_select != tccs_pkg::CMD_RESERVED &&
          active_sequence == tccs_pkg::CMD_NONE) begin
        active_sequence_next    = item.sequence_select;
        phase_next              = PH_WAKING;
        wake_attempt_count_next = 8'd0;
        step_position_next      = 3'd0;
        repeat_counter_next     = 6'd0;
        awake_latched_next      = 1'b0;
        next_due_ms_next        = now_ext;
        result.start_accepted   = 1'b1;
        result.status           = tccs_pkg::ST_PROCESSING;
      end else if (active_sequence != tccs_pkg::CMD_NONE) begin
        result.status = tccs_pkg::ST_PROCESSING;
      end
    end else if (active_sequence == tccs_pkg::CMD_NONE) begin
      result.status = tccs_pkg::ST_IDLE;
    end else if (early) begin
      result.status = tccs_pkg::ST_PROCESSING;
    end else if (phase == PH_WAKING) begin
      if (latched || wake_attempt_count >= 8'(WAKE_ATTEMPT_LIMIT)) begin
        result.status    = latched ? tccs_pkg::ST_WAKE_OK : tccs_pkg::ST_WAKE_TMO;
        phase_next       = PH_WAKE_WAIT;
        addend           = tccs_pkg::WAKE_SETTLE_MS;
        next_due_ms_next = due_sum;
      end else begin
        result.send_valid       = 1'b1;
        result.frame_index      = tccs_pkg::FR_WAKEUP;
        result.status           = tccs_pkg::ST_PROCESSING;
        wake_attempt_count_next = wake_attempt_count + 8'd1;
        addend                  = tccs_pkg::WAKE_PERIOD_MS;
        next_due_ms_next        = due_sum;
      end
    end else if (phase == PH_WAKE_WAIT) begin
      phase_next          = PH_RUN;
      step_position_next  = 3'd0;
      repeat_counter_next = 6'd0;
      next_due_ms_next    = now_ext;
      result.status       = tccs_pkg::ST_PROCESSING;
    end else if (phase == PH_RUN && step_position < len) begin
      result.send_valid     = 1'b1;
      result.frame_index    = step.frame;
      result.patch_setpoint = step.patch;
      result.setpoint_byte  = step.patch ? setpoint : 8'd0;
      result.status         = tccs_pkg::ST_PROCESSING;
      if (repeat_inc >= step.repeats) begin
        step_position_next  = step_position + 3'd1;
        repeat_counter_next = 6'd0;
        addend              = step.wait_ms;
      end else begin
        repeat_counter_next = repeat_inc;
        addend              = step.interval;
      end
      next_due_ms_next = due_sum;
    end else begin
      active_sequence_next = tccs_pkg::CMD_NONE;
      phase_next           = PH_IDLE;
      result.status        = tccs_pkg::ST_FINISHED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sequence    <= tccs_pkg::CMD_NONE;
      phase              <= PH_IDLE;
      wake_attempt_count <= 8'd0;
      step_position      <= 3'd0;
      repeat_counter     <= 6'd0;
      next_due_ms        <= '0;
      awake_latched      <= 1'b0;
    end else if (fire) begin
      active_sequence    <= active_sequence_next;
      phase              <= phase_next;
      wake_attempt_count <= wake_attempt_count_next;
      step_position      <= step_position_next;
      repeat_counter     <= repeat_counter_next;
      next_due_ms        <= next_due_ms_next;
      awake_latched      <= awake_latched_next;
    end
  end

endmodule
